@@ rtl/srs_pkg.sv @@
package srs_pkg;

  localparam int WINDOW_MAX = 32;
  localparam int STAMP_BITS = 32;
  localparam int RING_BITS = 6;
  localparam int SEQ_BITS = 17;
  localparam int HALF_RING = 32;
  localparam int WIN_CEIL = (WINDOW_MAX < HALF_RING) ? WINDOW_MAX : HALF_RING;
  localparam int THRESH_FLOOR = 8;
  localparam int FAST_EXTRA = 3;
  localparam int DUP_TRIGGER = 3;
  localparam logic [15:0] RST_PACKET_COUNT = 16'd1;
  localparam logic [15:0] RST_THRESHOLD = 16'd8;
  localparam logic [15:0] RST_TIMEOUT = 16'd300;
  localparam logic [5:0] RST_WINDOW = 6'd1;

  typedef enum logic [1:0] {
    KIND_TICK = 2'd0,
    KIND_ACK  = 2'd1,
    KIND_POLL = 2'd2,
    KIND_NONE = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    REASON_FIRST   = 2'd0,
    REASON_TIMEOUT = 2'd1,
    REASON_FAST    = 2'd2,
    REASON_SPARE   = 2'd3
  } reason_t;

  typedef enum logic [1:0] {
    MODE_SLOW  = 2'd0,
    MODE_AVOID = 2'd1,
    MODE_FAST  = 2'd2,
    MODE_HOLD  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    CFG_PACKET_COUNT = 2'd0,
    CFG_INIT_WINDOW  = 2'd1,
    CFG_INIT_THRESH  = 2'd2,
    CFG_TIMEOUT      = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic ack;
    logic [1:0] dup;
    logic run;
    logic [STAMP_BITS-1:0] start;
  } ring_row_t;

  typedef struct packed {
    logic capture;
    logic tick_inc;
    logic ptr_base;
    logic ptr_ack;
    logic ptr_ackp1;
    logic ptr_next;
    logic ptr_inc;
    logic base_inc;
    logic wr_poll;
    logic wr_timeout;
    logic wr_retx;
    logic wr_ack_new;
    logic wr_dup;
    logic wr_fast;
    logic set_res;
    reason_t res_reason;
    logic load_out;
  } srs_cmd_t;

  typedef struct packed {
    kind_t kind;
    logic ack_bad;
    logic mark;
    logic below_base;
    logic at_base;
    logic dup_trig;
    logic scan_done;
    logic expired;
    logic walk_ok;
    logic retx_ok;
    logic poll_ok;
    logic out_free;
  } srs_stat_t;

  function automatic logic [5:0] clamp_window(input logic [SEQ_BITS-1:0] w);
    logic [5:0] r;
    if (w > SEQ_BITS'(WIN_CEIL)) begin
      r = 6'(WIN_CEIL);
    end else if (w == '0) begin
      r = 6'd1;
    end else begin
      r = w[5:0];
    end
    return r;
  endfunction

endpackage

@@ rtl/selective_repeat_sender_cc.sv @@
// Selective-repeat sender with a Reno-like congestion window.
// The input channel carries one event per transfer: tuser holds the kind
// (tick, acknowledgement, send poll) and tdata the acknowledged sequence
// number. The output channel carries at most one send per event: tdata holds
// the sequence number, the window after the event and the all-acked flag,
// and tuser the reason (first send, timeout retransmit, fast retransmit).
// The configuration channel writes packet count, initial window, initial
// threshold and timeout; it is always ready and is to be used only while idle, which the block itself does not enforce.
// Each event is processed alone through a state sequencer and one ring
// memory port. A poll checks the next sequence number; a tick checks the
// window entries from the base up to the first one that expires; an
// acknowledgement reads its entry, then walks the base forward over acked
// entries when it acknowledges the base, or checks the entry after it when
// it triggers a fast retransmit. An event that sends keeps the input not
// ready until its send has been loaded into the registered output.
// A stalled output holds its transfer while the next event is accepted;
// a second send then waits until the first one has been taken.
// Reset returns the sender state and configuration to their start values and clears the ring marks.
module selective_repeat_sender_cc
  import srs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // ack_seq
  input  logic [1:0]  in_tuser,   // kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // send_seq, window_now, all_acked, zero pad
  output logic [1:0]  out_tuser,  // send_reason
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  srs_cmd_t cmd;
  srs_stat_t st;

  assign cfg_ready = 1'b1;

  srs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  srs_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .st         (st),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

@@ rtl/srs_ctrl.sv @@
module srs_ctrl
  import srs_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  input  srs_stat_t st,
  output srs_cmd_t  cmd
);

  typedef enum logic [10:0] {
    S_IDLE    = 11'b00000000001,
    S_DISP    = 11'b00000000010,
    S_TICK_RD = 11'b00000000100,
    S_TICK_CK = 11'b00000001000,
    S_ACK_RD  = 11'b00000010000,
    S_ACK_CK  = 11'b00000100000,
    S_RETX_RD = 11'b00001000000,
    S_RETX_CK = 11'b00010000000,
    S_WALK_RD = 11'b00100000000,
    S_WALK_CK = 11'b01000000000,
    S_POLL    = 11'b10000000000
  } state_t;

  state_t state_r, state_nxt;
  logic emit_r, emit_nxt;

  assign in_tready = (state_r == S_IDLE) && !emit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      emit_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      emit_r <= emit_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    emit_nxt = emit_r;
    cmd = '0;
    if (emit_r && st.out_free) begin
      cmd.load_out = 1'b1;
      emit_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid && in_tready) begin
          cmd.capture = 1'b1;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        unique case (st.kind)
          KIND_TICK: begin
            cmd.tick_inc = 1'b1;
            cmd.ptr_base = 1'b1;
            state_nxt = S_TICK_RD;
          end
          KIND_ACK: begin
            if (st.ack_bad) begin
              state_nxt = S_IDLE;
            end else begin
              cmd.ptr_ack = 1'b1;
              state_nxt = S_ACK_RD;
            end
          end
          KIND_POLL: begin
            cmd.ptr_next = 1'b1;
            state_nxt = S_POLL;
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_POLL: begin
        if (st.poll_ok) begin
          cmd.wr_poll = 1'b1;
          cmd.set_res = 1'b1;
          cmd.res_reason = REASON_FIRST;
          emit_nxt = 1'b1;
        end
        state_nxt = S_IDLE;
      end
      S_TICK_RD: begin
        state_nxt = st.scan_done ? S_IDLE : S_TICK_CK;
      end
      S_TICK_CK: begin
        if (st.expired) begin
          cmd.wr_timeout = 1'b1;
          cmd.set_res = 1'b1;
          cmd.res_reason = REASON_TIMEOUT;
          emit_nxt = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          cmd.ptr_inc = 1'b1;
          state_nxt = S_TICK_RD;
        end
      end
      S_ACK_RD: state_nxt = S_ACK_CK;
      S_ACK_CK: begin
        if (!st.mark) begin
          if (st.below_base) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.wr_ack_new = 1'b1;
            state_nxt = st.at_base ? S_WALK_RD : S_IDLE;
          end
        end else if (!st.dup_trig) begin
          cmd.wr_dup = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          cmd.wr_fast = 1'b1;
          cmd.ptr_ackp1 = 1'b1;
          state_nxt = S_RETX_RD;
        end
      end
      S_RETX_RD: state_nxt = st.retx_ok ? S_RETX_CK : S_IDLE;
      S_RETX_CK: begin
        if (!st.mark) begin
          cmd.wr_retx = 1'b1;
          cmd.set_res = 1'b1;
          cmd.res_reason = REASON_FAST;
          emit_nxt = 1'b1;
        end
        state_nxt = S_IDLE;
      end
      S_WALK_RD: state_nxt = st.walk_ok ? S_WALK_CK : S_IDLE;
      S_WALK_CK: begin
        if (st.mark) begin
          cmd.base_inc = 1'b1;
          cmd.ptr_inc = 1'b1;
          state_nxt = S_WALK_RD;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

@@ rtl/srs_dp.sv @@
module srs_dp
  import srs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  srs_cmd_t    cmd,
  output srs_stat_t   st,
  input  logic [15:0] in_tdata,
  input  logic [1:0]  in_tuser,
  input  logic        cfg_valid,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,
  output logic [1:0]  out_tuser
);

  localparam int RING = 1 << RING_BITS;

  logic [15:0] pc_r, to_r;
  logic [SEQ_BITS-1:0] base_r, next_r, ptr_r;
  logic [15:0] acked_r, thr_r, ack_r;
  logic [5:0] cw_r;
  mode_t mode_r;
  kind_t kind_r;
  logic [STAMP_BITS-1:0] tick_r;
  logic [15:0] res_seq_r;
  reason_t res_reason_r;
  logic out_valid_r;
  logic [15:0] out_seq_r;
  logic [1:0] out_reason_r;
  logic [5:0] out_win_r;
  logic out_all_r;

  ring_row_t ring_mem [RING];
  logic [RING-1:0] ring_vld_r;
  ring_row_t rd_raw_r;
  logic rd_vld_r;
  ring_row_t rd;
  ring_row_t wr_row;
  logic wr_en;
  logic [RING_BITS-1:0] idx;

  logic [SEQ_BITS-1:0] win_end, ack_ext, ackp1;
  logic [15:0] halved;
  logic [5:0] cw_grow;
  mode_t mode_grow;
  logic [2:0] dup_inc;
  logic [6:0] dbl;
  logic all_acked;

  assign idx = ptr_r[RING_BITS-1:0];
  assign rd = rd_vld_r ? rd_raw_r : '0;
  assign win_end = base_r + SEQ_BITS'(cw_r);
  assign ack_ext = {1'b0, ack_r};
  assign ackp1 = ack_ext + SEQ_BITS'(1);
  assign halved = (cw_r[5:1] > 5'(THRESH_FLOOR)) ? {11'd0, cw_r[5:1]} : 16'(THRESH_FLOOR);
  assign dup_inc = {1'b0, rd.dup} + 3'd1;
  assign dbl = {cw_r, 1'b0};
  assign all_acked = acked_r >= pc_r;

  always_comb begin
    cw_grow = cw_r;
    mode_grow = mode_r;
    case (mode_r)
      MODE_SLOW: begin
        cw_grow = clamp_window(SEQ_BITS'(dbl));
        if ({9'd0, dbl} >= thr_r) begin
          mode_grow = MODE_AVOID;
        end
      end
      MODE_AVOID: cw_grow = clamp_window(SEQ_BITS'(cw_r) + SEQ_BITS'(1));
      MODE_FAST: begin
        cw_grow = clamp_window({1'b0, thr_r});
        mode_grow = MODE_AVOID;
      end
      default: cw_grow = clamp_window(SEQ_BITS'(cw_r));
    endcase
  end

  always_comb begin
    st.kind = kind_r;
    st.ack_bad = (ack_r == '0) || (ack_ext >= next_r) ||
                 (ack_ext + SEQ_BITS'(HALF_RING) < base_r);
    st.mark = rd.ack;
    st.below_base = ack_ext < base_r;
    st.at_base = ack_ext == base_r;
    st.dup_trig = dup_inc >= 3'(DUP_TRIGGER);
    st.scan_done = (ptr_r >= win_end) || (ptr_r >= next_r);
    st.expired = !rd.ack && rd.run && ((tick_r - rd.start) >= STAMP_BITS'(to_r));
    st.walk_ok = (base_r < next_r) && (base_r <= {1'b0, pc_r});
    st.retx_ok = ptr_r < next_r;
    st.poll_ok = (next_r <= {1'b0, pc_r}) && (next_r < win_end);
    st.out_free = !out_valid_r || out_tready;
  end

  always_comb begin
    wr_en = 1'b1;
    wr_row = rd;
    if (cmd.wr_poll) begin
      wr_row = '{ack: 1'b0, dup: 2'd0, run: 1'b1, start: tick_r};
    end else if (cmd.wr_timeout || cmd.wr_retx) begin
      wr_row.run = 1'b1;
      wr_row.start = tick_r;
    end else if (cmd.wr_ack_new) begin
      wr_row.ack = 1'b1;
      wr_row.dup = 2'd1;
      wr_row.run = 1'b0;
    end else if (cmd.wr_dup) begin
      wr_row.dup = dup_inc[1:0];
    end else if (cmd.wr_fast) begin
      wr_row.dup = 2'd1;
    end else begin
      wr_en = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ring_mem[idx] <= wr_row;
    end
    rd_raw_r <= ring_mem[idx];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ring_vld_r <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        ring_vld_r[idx] <= 1'b1;
      end
      rd_vld_r <= ring_vld_r[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= RST_PACKET_COUNT;
      to_r <= RST_TIMEOUT;
      base_r <= SEQ_BITS'(1);
      next_r <= SEQ_BITS'(1);
      acked_r <= '0;
      cw_r <= clamp_window(SEQ_BITS'(RST_WINDOW));
      thr_r <= RST_THRESHOLD;
      mode_r <= MODE_SLOW;
      tick_r <= '0;
      kind_r <= KIND_NONE;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_PACKET_COUNT: pc_r <= cfg_data;
          CFG_INIT_WINDOW: begin
            if (next_r == SEQ_BITS'(1)) begin
              cw_r <= clamp_window(SEQ_BITS'(cfg_data[5:0]));
            end
          end
          CFG_INIT_THRESH: begin
            if (next_r == SEQ_BITS'(1)) begin
              thr_r <= cfg_data;
            end
          end
          CFG_TIMEOUT: to_r <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.capture) begin
        kind_r <= kind_t'(in_tuser);
      end
      if (cmd.tick_inc) begin
        tick_r <= tick_r + STAMP_BITS'(1);
      end
      if (cmd.wr_poll) begin
        next_r <= next_r + SEQ_BITS'(1);
      end
      if (cmd.base_inc) begin
        base_r <= base_r + SEQ_BITS'(1);
      end
      if (cmd.wr_timeout) begin
        thr_r <= halved;
        cw_r <= 6'd1;
        mode_r <= MODE_SLOW;
      end
      if (cmd.wr_ack_new) begin
        acked_r <= acked_r + 16'd1;
        cw_r <= cw_grow;
        mode_r <= mode_grow;
      end
      if (cmd.wr_fast) begin
        thr_r <= halved;
        cw_r <= clamp_window({1'b0, halved} + SEQ_BITS'(FAST_EXTRA));
        mode_r <= MODE_FAST;
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      ack_r <= in_tdata;
    end
    if (cmd.ptr_base) begin
      ptr_r <= base_r;
    end else if (cmd.ptr_ack) begin
      ptr_r <= ack_ext;
    end else if (cmd.ptr_ackp1) begin
      ptr_r <= ackp1;
    end else if (cmd.ptr_next) begin
      ptr_r <= next_r;
    end else if (cmd.ptr_inc) begin
      ptr_r <= ptr_r + SEQ_BITS'(1);
    end
    if (cmd.set_res) begin
      res_seq_r <= ptr_r[15:0];
      res_reason_r <= cmd.res_reason;
    end
    if (cmd.load_out) begin
      out_seq_r <= res_seq_r;
      out_reason_r <= res_reason_r;
      out_win_r <= cw_r;
      out_all_r <= all_acked;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata = {1'b0, out_all_r, out_win_r, out_seq_r};
  assign out_tuser = out_reason_r;

endmodule

@@ bench/tb_top.sv @@
module tb_top;
  import srs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 1500000;
  localparam int DRAIN_CYCLES = 200;

  typedef struct {
    logic [15:0] seq;
    reason_t     reason;
    logic [5:0]  win;
    logic        done;
  } send_t;

  typedef struct {
    kind_t       kind;
    logic [15:0] ack;
  } event_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic [1:0]  in_tuser = KIND_NONE;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  selective_repeat_sender_cc dut (.*);

  always #5 clk = ~clk;

  // Sender state as the block should hold it.
  int          snd_base, snd_next;
  logic [15:0] acked_cnt;
  int          cwnd, ssthresh;
  mode_t       cmode;
  logic        mark [64];
  int          dupc [64];
  logic        trun [64];
  logic [31:0] tstart [64];
  logic [31:0] tick_cnt;
  int          reg_pkts, reg_iwin, reg_ithr, reg_tmo;

  event_t pending[$];
  send_t  sends_due[$];
  int     errors = 0;
  int     cycles = 0;
  bit     no_gaps = 0;
  int     in_gap = 0;
  int     out_gap = 0;

  function automatic int sat_window(int w);
    if (w > WIN_CEIL) return WIN_CEIL;
    if (w < 1) return 1;
    return w;
  endfunction

  function automatic int halve_thresh();
    return (cwnd / 2 > THRESH_FLOOR) ? cwnd / 2 : THRESH_FLOOR;
  endfunction

  function automatic void queue_send(int seq, reason_t why);
    send_t s;
    s.seq = seq[15:0];
    s.reason = why;
    s.win = cwnd[5:0];
    s.done = (int'(acked_cnt) >= reg_pkts);
    sends_due.push_back(s);
  endfunction

  function automatic void restart_timer(int seq);
    trun[seq & 63] = 1'b1;
    tstart[seq & 63] = tick_cnt;
  endfunction

  function automatic void reset_sender();
    reg_pkts = 1;
    reg_iwin = 1;
    reg_ithr = 8;
    reg_tmo = 300;
    snd_base = 1;
    snd_next = 1;
    acked_cnt = '0;
    cwnd = 1;
    ssthresh = 8;
    cmode = MODE_SLOW;
    tick_cnt = '0;
    for (int i = 0; i < 64; i++) begin
      mark[i] = 1'b0;
      dupc[i] = 0;
      trun[i] = 1'b0;
      tstart[i] = '0;
    end
  endfunction

  function automatic void apply_reg(cfg_idx_t idx, logic [15:0] v);
    case (idx)
      CFG_PACKET_COUNT: reg_pkts = int'(v);
      CFG_INIT_WINDOW: begin
        reg_iwin = int'(v[5:0]);
        if (snd_next == 1) cwnd = sat_window(reg_iwin);
      end
      CFG_INIT_THRESH: begin
        reg_ithr = int'(v);
        if (snd_next == 1) ssthresh = reg_ithr;
      end
      default: reg_tmo = int'(v);
    endcase
  endfunction

  function automatic void grow_cwnd();
    int w;
    w = cwnd;
    case (cmode)
      MODE_SLOW: begin
        w = cwnd * 2;
        if (w >= ssthresh) cmode = MODE_AVOID;
      end
      MODE_AVOID: w = cwnd + 1;
      MODE_FAST: begin
        w = ssthresh;
        cmode = MODE_AVOID;
      end
      default: ;
    endcase
    cwnd = sat_window(w);
  endfunction

  function automatic void advance_sender(kind_t k, logic [15:0] ack);
    int a, last, r, i;
    a = int'(ack);
    i = a & 63;
    case (k)
      KIND_TICK: begin
        tick_cnt = tick_cnt + 32'd1;
        last = snd_base + cwnd;
        if (last > snd_next) last = snd_next;
        for (int s = snd_base; s < last; s++) begin
          if (!mark[s & 63] && trun[s & 63] &&
              (tick_cnt - tstart[s & 63]) >= 32'(reg_tmo)) begin
            ssthresh = halve_thresh();
            cwnd = 1;
            cmode = MODE_SLOW;
            restart_timer(s);
            queue_send(s, REASON_TIMEOUT);
            break;
          end
        end
      end
      KIND_ACK: begin
        if (a == 0 || a >= snd_next || a + HALF_RING < snd_base) return;
        if (!mark[i]) begin
          if (a < snd_base) return;
          mark[i] = 1'b1;
          dupc[i] = 1;
          trun[i] = 1'b0;
          acked_cnt = acked_cnt + 16'd1;
          grow_cwnd();
          if (a == snd_base)
            while (snd_base < snd_next && snd_base <= reg_pkts && mark[snd_base & 63])
              snd_base++;
        end else if (dupc[i] + 1 < DUP_TRIGGER) begin
          dupc[i]++;
        end else begin
          r = a + 1;
          dupc[i] = 1;
          ssthresh = halve_thresh();
          cwnd = sat_window(ssthresh + FAST_EXTRA);
          cmode = MODE_FAST;
          if (r < snd_next && !mark[r & 63]) begin
            restart_timer(r);
            queue_send(r, REASON_FAST);
          end
        end
      end
      KIND_POLL: begin
        if (snd_next > reg_pkts || snd_next >= snd_base + cwnd) return;
        mark[snd_next & 63] = 1'b0;
        dupc[snd_next & 63] = 0;
        restart_timer(snd_next);
        queue_send(snd_next, REASON_FIRST);
        snd_next++;
      end
      default: ;
    endcase
  endfunction

  function automatic int pick_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        advance_sender(kind_t'(in_tuser), in_tdata);
        in_gap = pick_gap();
      end
      if (!(in_tvalid && !in_tready)) begin
        if (in_gap > 0) begin
          in_gap--;
          in_tvalid <= 1'b0;
        end else if (pending.size() > 0) begin
          event_t e;
          e = pending.pop_front();
          in_tvalid <= 1'b1;
          in_tuser <= e.kind;
          in_tdata <= e.ack;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (sends_due.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected send: seq %0d reason %0d win %0d all %0d",
                     out_tdata[15:0], out_tuser, out_tdata[21:16], out_tdata[22]);
        end else begin
          send_t x;
          x = sends_due.pop_front();
          if (out_tdata[15:0] !== x.seq || out_tuser !== x.reason ||
              out_tdata[21:16] !== x.win || out_tdata[22] !== x.done ||
              out_tdata[23] !== 1'b0) begin
            errors++;
            if (errors <= 10)
              $display({"send mismatch: expected seq %0d reason %0d win %0d all %0d,",
                        " got %0d %0d %0d %0d"},
                       x.seq, x.reason, x.win, x.done, out_tdata[15:0], out_tuser,
                       out_tdata[21:16], out_tdata[22]);
          end
        end
        out_gap = pick_gap();
      end
      if (out_gap > 0) begin
        out_gap--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("selective_repeat_sender_cc regression: fail");
      $finish;
    end
  end

  task automatic write_reg(cfg_idx_t idx, logic [15:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_reg(idx, v);
    cfg_valid <= 1'b0;
  endtask

  task automatic push_event(kind_t k, logic [15:0] a);
    event_t e;
    e.kind = k;
    e.ack = a;
    while (pending.size() >= 2) @(posedge clk);
    pending.push_back(e);
  endtask

  task automatic wait_idle();
    @(posedge clk);
    while (pending.size() > 0 || in_tvalid || in_gap > 0 || sends_due.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic random_event();
    int r, lo;
    logic [15:0] a;
    r = $urandom_range(0, 99);
    if (r < 30) begin
      push_event(KIND_TICK, 16'($urandom));
    end else if (r < 58) begin
      lo = (snd_base > 3) ? snd_base - 3 : 0;
      push_event(KIND_ACK, 16'($urandom_range(lo, snd_next + 1)));
    end else if (r < 66) begin
      a = (snd_base > 1) ? 16'(snd_base - 1) : 16'($urandom_range(1, 3));
      repeat (3) push_event(KIND_ACK, a);
    end else if (r < 72) begin
      push_event(KIND_ACK, 16'($urandom));
    end else if (r < 96) begin
      push_event(KIND_POLL, 16'($urandom));
    end else begin
      push_event(KIND_NONE, 16'($urandom));
    end
  endtask

  initial begin
    int plan_pkts[6] = '{1, 40, 300, 600, 65535, 65535};
    int plan_tmo[6] = '{2, 3, 65535, 20, 1, 8};
    int plan_len[6] = '{40, 330, 330, 330, 330, 300};
    reset_sender();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    write_reg(CFG_PACKET_COUNT, 16'd4);
    write_reg(CFG_INIT_WINDOW, 16'd1);
    write_reg(CFG_INIT_THRESH, 16'd65535);
    write_reg(CFG_TIMEOUT, 16'd1);

    // Sends up to the packet count, bad acks, a triple duplicate and timeouts.
    repeat (5) push_event(KIND_POLL, 16'h0000);
    push_event(KIND_ACK, 16'h0000);
    push_event(KIND_ACK, 16'hFFFF);
    push_event(KIND_ACK, 16'd1);
    repeat (5) push_event(KIND_POLL, 16'h0000);
    push_event(KIND_ACK, 16'd1);
    push_event(KIND_ACK, 16'd1);
    push_event(KIND_ACK, 16'd3);
    push_event(KIND_TICK, 16'h0000);
    push_event(KIND_TICK, 16'hFFFF);
    push_event(KIND_NONE, 16'hFFFF);
    push_event(KIND_ACK, 16'd2);
    push_event(KIND_ACK, 16'd4);
    push_event(KIND_POLL, 16'h0000);
    wait_idle();

    for (int p = 0; p < 6; p++) begin
      write_reg(CFG_PACKET_COUNT, 16'(plan_pkts[p]));
      write_reg(CFG_TIMEOUT, 16'(plan_tmo[p]));
      write_reg(CFG_INIT_WINDOW, (p % 2) ? 16'd32 : 16'd1);
      write_reg(CFG_INIT_THRESH, (p % 2) ? 16'd1 : 16'd65535);
      no_gaps = (p == 2);
      for (int n = 0; n < plan_len[p]; n++) random_event();
      wait_idle();
    end

    if (errors == 0) begin
      $display("selective_repeat_sender_cc regression: pass");
    end else begin
      $display("selective_repeat_sender_cc regression: fail");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/srs_pkg.sv
rtl/srs_ctrl.sv
rtl/srs_dp.sv
rtl/selective_repeat_sender_cc.sv
bench/tb_top.sv
